// ===== hw/rtl/ffha_pkg.sv =====
`default_nettype none

package ffha_pkg;

  // Heap geometry
  localparam int HEAP_BYTES   = 1024 * 256;
  localparam int HEADER_BYTES = 12;
  localparam int ALIGN_UNIT   = 8;
  localparam int MAX_BLOCKS   = 1024;

  localparam int SLOT_W  = $clog2(MAX_BLOCKS);
  localparam int OFF_W   = 18;
  localparam int USED_W  = 19;
  localparam int GUARD_W = SLOT_W + 2;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // One entry of the block table
  typedef struct packed {
    logic [OFF_W-1:0]  size;
    logic              free;
    logic [SLOT_W-1:0] next;
    logic              has_next;
  } blk_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a 256 KiB heap with 12-byte block headers and
// 8-byte size rounding. The block list lives in a 1024-entry table with one read
// and one write port; after reset a clearing pass over all 1024 entries runs before the
// first item is taken.
// The run time of every item is then set by its accesses to that table: a walk
// over the blocks in address order, a scan of the slots when a split needs a
// spare slot, and for a successful free a merge pass over the blocks; then the
// result is handed to the output register. A zero-size allocate skips the walk and
// fails with a no-fit status. One item is in flight at a time; the next one is
// taken while the previous result still waits in the output register.
`default_nettype none

module first_fit_heap_allocator import ffha_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_command,
  input  wire logic [OFF_W-1:0]  in_request_bytes,
  input  wire logic [OFF_W-1:0]  in_release_offset,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OFF_W-1:0]       out_payload_offset,
  output logic [1:0]             out_status,
  output logic [USED_W-1:0]      out_used_bytes
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WALK_RD, S_WALK_CHK, S_SCAN_RD, S_SCAN_CHK,
    S_SPLIT_A, S_SPLIT_B, S_MRG_LD, S_MRG_CUR, S_MRG_TEST, S_MRG_NX,
    S_MRG_KILL, S_DONE
  } state_t;

  // Block table and slot occupancy
  blk_rec_t    rec_mem  [MAX_BLOCKS];
  logic        slot_mem [MAX_BLOCKS];
  blk_rec_t    rec_rd_r;
  logic        slot_rd_r;

  logic              rec_we, slot_we, slot_wdata;
  logic [SLOT_W-1:0] rec_waddr, rec_raddr, slot_waddr, slot_raddr;
  blk_rec_t          rec_wdata;

  state_t             state_r, state_nxt;
  logic               cmd_r, cmd_nxt;
  logic [USED_W-1:0]  need_r, need_nxt;
  logic [OFF_W-1:0]   rel_r, rel_nxt;
  logic [SLOT_W-1:0]  cur_r, cur_nxt, nx_r, nx_nxt, scan_r, scan_nxt, steps_r, steps_nxt;
  logic [USED_W-1:0]  off_r, off_nxt, used_r, used_nxt;
  logic [GUARD_W-1:0] guard_r, guard_nxt;
  blk_rec_t           cur_rec_r, cur_rec_nxt, nx_rec_r, nx_rec_nxt;
  logic [OFF_W-1:0]   res_off_r, res_off_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]   out_off_r, out_off_nxt;
  logic [1:0]         out_st_r, out_st_nxt;
  logic [USED_W-1:0]  out_used_r, out_used_nxt;

  logic [USED_W-1:0]  rd_total, left, in_need;
  logic               alloc_hit, free_hit;

  assign rd_total  = {1'b0, rec_rd_r.size} + USED_W'(HEADER_BYTES);
  assign left      = {1'b0, rec_rd_r.size} - need_r;
  assign alloc_hit = rec_rd_r.free && ({1'b0, rec_rd_r.size} >= need_r);
  assign free_hit  = (off_r + USED_W'(HEADER_BYTES)) == {1'b0, rel_r};
  assign in_need   = ({1'b0, in_request_bytes} + USED_W'(ALIGN_UNIT - 1))
                     & ~USED_W'(ALIGN_UNIT - 1);

  // Sequencer and datapath next values
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    need_nxt    = need_r;
    rel_nxt     = rel_r;
    cur_nxt     = cur_r;
    nx_nxt      = nx_r;
    scan_nxt    = scan_r;
    steps_nxt   = steps_r;
    off_nxt     = off_r;
    used_nxt    = used_r;
    guard_nxt   = guard_r;
    cur_rec_nxt = cur_rec_r;
    nx_rec_nxt  = nx_rec_r;
    res_off_nxt = res_off_r;
    res_st_nxt  = res_st_r;
    rec_we      = 1'b0;
    rec_waddr   = cur_r;
    rec_wdata   = rec_rd_r;
    rec_raddr   = cur_r;
    slot_we     = 1'b0;
    slot_waddr  = scan_r;
    slot_wdata  = 1'b1;
    slot_raddr  = scan_r;
    in_ready    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_off_nxt   = out_off_r;
    out_st_nxt    = out_st_r;
    out_used_nxt  = out_used_r;

    unique case (state_r)
      // Sweep the table to its reset contents
      S_CLR: begin
        rec_we     = 1'b1;
        rec_waddr  = scan_r;
        rec_wdata  = '0;
        slot_we    = 1'b1;
        slot_waddr = scan_r;
        slot_wdata = (scan_r == '0);
        if (scan_r == '0) begin
          rec_wdata.size = OFF_W'(HEAP_BYTES - HEADER_BYTES);
          rec_wdata.free = 1'b1;
        end
        scan_nxt = scan_r + 1'b1;
        if (scan_r == SLOT_W'(MAX_BLOCKS - 1)) state_nxt = S_IDLE;
      end

      // Take an item and start the walk from the first block; a zero-size allocate goes straight to the result
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt     = in_command;
          need_nxt    = in_need;
          rel_nxt     = in_release_offset;
          cur_nxt     = '0;
          off_nxt     = '0;
          steps_nxt   = '0;
          res_off_nxt = '0;
          res_st_nxt  = ST_OK;
          if (in_command == CMD_ALLOC && in_request_bytes == '0) begin
            res_st_nxt = ST_NO_FIT;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_WALK_RD;
          end
        end
      end

      S_WALK_RD: state_nxt = S_WALK_CHK;

      // Test one block, then grant, release, fail or advance
      S_WALK_CHK: begin
        cur_rec_nxt = rec_rd_r;
        if (cmd_r == CMD_ALLOC && alloc_hit) begin
          res_off_nxt = OFF_W'(off_r + USED_W'(HEADER_BYTES));
          if (left >= USED_W'(HEADER_BYTES + ALIGN_UNIT)) begin
            scan_nxt  = '0;
            state_nxt = S_SCAN_RD;
          end else begin
            rec_we         = 1'b1;
            rec_wdata.free = 1'b0;
            used_nxt       = used_r + rd_total;
            state_nxt      = S_DONE;
          end
        end else if (cmd_r == CMD_FREE && free_hit) begin
          if (rec_rd_r.free) begin
            res_st_nxt = ST_BAD_FREE;
            state_nxt  = S_DONE;
          end else begin
            rec_we         = 1'b1;
            rec_wdata.free = 1'b1;
            used_nxt       = (used_r >= rd_total) ? used_r - rd_total : '0;
            cur_nxt        = '0;
            guard_nxt      = '0;
            state_nxt      = S_MRG_LD;
          end
        end else if (!rec_rd_r.has_next || steps_r == SLOT_W'(MAX_BLOCKS - 1)) begin
          res_st_nxt = (cmd_r == CMD_ALLOC) ? ST_NO_FIT : ST_BAD_FREE;
          state_nxt  = S_DONE;
        end else begin
          cur_nxt   = rec_rd_r.next;
          off_nxt   = off_r + rd_total;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_WALK_RD;
        end
      end

      S_SCAN_RD: state_nxt = S_SCAN_CHK;

      // Look for the lowest spare slot; grant whole block if none
      S_SCAN_CHK: begin
        if (!slot_rd_r) begin
          state_nxt = S_SPLIT_A;
        end else if (scan_r == SLOT_W'(MAX_BLOCKS - 1)) begin
          rec_we         = 1'b1;
          rec_wdata      = cur_rec_r;
          rec_wdata.free = 1'b0;
          used_nxt       = used_r + {1'b0, cur_rec_r.size} + USED_W'(HEADER_BYTES);
          state_nxt      = S_DONE;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end

      // Write the split-off free remainder
      S_SPLIT_A: begin
        rec_we             = 1'b1;
        rec_waddr          = scan_r;
        rec_wdata.size     = cur_rec_r.size - need_r[OFF_W-1:0] - OFF_W'(HEADER_BYTES);
        rec_wdata.free     = 1'b1;
        rec_wdata.next     = cur_rec_r.next;
        rec_wdata.has_next = cur_rec_r.has_next;
        slot_we            = 1'b1;
        state_nxt          = S_SPLIT_B;
      end

      // Shrink the granted block and link it to the remainder
      S_SPLIT_B: begin
        rec_we             = 1'b1;
        rec_wdata.size     = need_r[OFF_W-1:0];
        rec_wdata.free     = 1'b0;
        rec_wdata.next     = scan_r;
        rec_wdata.has_next = 1'b1;
        used_nxt           = used_r + need_r + USED_W'(HEADER_BYTES);
        state_nxt          = S_DONE;
      end

      S_MRG_LD: state_nxt = S_MRG_CUR;

      S_MRG_CUR: begin
        cur_rec_nxt = rec_rd_r;
        state_nxt   = S_MRG_TEST;
      end

      // Stop at list end or when the guard runs out, else fetch the neighbor
      S_MRG_TEST: begin
        rec_raddr = cur_rec_r.next;
        nx_nxt    = cur_rec_r.next;
        if (!cur_rec_r.has_next || guard_r == GUARD_W'(2 * MAX_BLOCKS)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MRG_NX;
        end
      end

      // Absorb a free neighbor into a free block, else step on
      S_MRG_NX: begin
        nx_rec_nxt = rec_rd_r;
        guard_nxt  = guard_r + 1'b1;
        if (cur_rec_r.free && rec_rd_r.free) begin
          cur_rec_nxt.size     = cur_rec_r.size + OFF_W'(HEADER_BYTES) + rec_rd_r.size;
          cur_rec_nxt.next     = rec_rd_r.next;
          cur_rec_nxt.has_next = rec_rd_r.has_next;
          rec_we               = 1'b1;
          rec_wdata            = cur_rec_nxt;
          slot_we              = 1'b1;
          slot_waddr           = nx_r;
          slot_wdata           = 1'b0;
          state_nxt            = S_MRG_KILL;
        end else begin
          cur_nxt     = nx_r;
          cur_rec_nxt = rec_rd_r;
          state_nxt   = S_MRG_TEST;
        end
      end

      // Retire the absorbed entry
      S_MRG_KILL: begin
        rec_we             = 1'b1;
        rec_waddr          = nx_r;
        rec_wdata          = nx_rec_r;
        rec_wdata.free     = 1'b0;
        rec_wdata.has_next = 1'b0;
        state_nxt          = S_MRG_TEST;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = res_off_r;
          out_st_nxt    = res_st_r;
          out_used_nxt  = used_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      scan_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    need_r     <= need_nxt;
    rel_r      <= rel_nxt;
    cur_r      <= cur_nxt;
    nx_r       <= nx_nxt;
    steps_r    <= steps_nxt;
    off_r      <= off_nxt;
    guard_r    <= guard_nxt;
    cur_rec_r  <= cur_rec_nxt;
    nx_rec_r   <= nx_rec_nxt;
    res_off_r  <= res_off_nxt;
    res_st_r   <= res_st_nxt;
    out_off_r  <= out_off_nxt;
    out_st_r   <= out_st_nxt;
    out_used_r <= out_used_nxt;
  end

  // Block table memory
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    rec_rd_r <= rec_mem[rec_raddr];
  end

  // Slot occupancy memory
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd_r <= slot_mem[slot_raddr];
  end

  assign out_valid          = out_valid_r;
  assign out_payload_offset = out_off_r;
  assign out_status         = out_st_r;
  assign out_used_bytes     = out_used_r;

  // One item at a time: no item right after one was taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in flight");

  // Failed requests carry no offset
  a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_payload_offset == '0)
    else $error("failed request returned an offset");

  // Used bytes never exceed the heap
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_used_bytes <= USED_W'(HEAP_BYTES))
    else $error("used byte count beyond heap size");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_NO_FIT
                  || out_status == ST_BAD_FREE)
    else $error("undefined status code");

endmodule

`default_nettype wire
